FILE: rtl/gpua_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpua_pkg
// Widths, reset values and sequencer states of the gravity-projected user
// acceleration unit.
// ----------------------------------------------------------------------------
package gpua_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int GRAV_BITS    = 16;
  localparam int USER_BITS    = 17;
  localparam int PROD_BITS    = 33;
  localparam int DOT_BITS     = 34;
  localparam int WIN_BITS     = 7;
  localparam int WIN_RESET    = 16;
  localparam int SUM_BITS     = SAMPLE_BITS + WIN_BITS;
  localparam int DIV_BITS     = SUM_BITS + (SUM_BITS % 2);
  localparam int DIV_STEPS    = DIV_BITS / 2;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);
  localparam int AXES         = 3;
  localparam int MUL_LAST     = AXES;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } gpua_state_t;

endpackage

FILE: rtl/gpua_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpua_in_if
// Sample channel: one three-axis accelerometer word per handshake.
// ----------------------------------------------------------------------------
interface gpua_in_if
  import gpua_pkg::*;
  ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z,
                output ready);
endinterface

FILE: rtl/gpua_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpua_out_if
// Result channel: gravity, user acceleration and their dot product per word.
// ----------------------------------------------------------------------------
interface gpua_out_if
  import gpua_pkg::*;
  ();
  logic                        valid;
  logic                        ready;
  logic signed [GRAV_BITS-1:0] gravity_x;
  logic signed [GRAV_BITS-1:0] gravity_y;
  logic signed [GRAV_BITS-1:0] gravity_z;
  logic signed [USER_BITS-1:0] user_x;
  logic signed [USER_BITS-1:0] user_y;
  logic signed [USER_BITS-1:0] user_z;
  logic signed [DOT_BITS-1:0]  dot_product;
  logic                        warmed_up;

  modport source (output valid, output gravity_x, output gravity_y, output gravity_z,
                  output user_x, output user_y, output user_z, output dot_product,
                  output warmed_up, input ready);
  modport sink (input valid, input gravity_x, input gravity_y, input gravity_z,
                input user_x, input user_y, input user_z, input dot_product,
                input warmed_up, output ready);
endinterface

FILE: rtl/gravity_projected_user_accel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_projected_user_accel_unit
// Moving-average gravity removal with a gravity/user-acceleration dot product.
// ----------------------------------------------------------------------------
// One sample word is taken at a time. Once a full window has been seen, a word
// goes through one history read, one sum update, the shared divider (two
// quotient bits per cycle) and the shared 17x16 multiplier, then the load of
// the result register; no new word is taken until then. During warm-up the
// divider is skipped. A finished result waits in its output register while the
// next sample is taken; the unit stalls before loading a new result only if
// the previous one is still unread. Writing the window register clears the
// fill count and the running sums; the history ring is kept. A window of 0 acts
// as 1, one above WINDOW_MAX acts as WINDOW_MAX.
// ----------------------------------------------------------------------------
module gravity_projected_user_accel_unit
  import gpua_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  logic                clk,
  input  logic                rst,
  gpua_in_if.sink             sample,
  gpua_out_if.source          result,
  input  logic                cfg_wr_en,
  input  logic [WIN_BITS-1:0] cfg_wr_data
);

  localparam int PTR_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CALC_BITS = ((PTR_BITS > WIN_BITS) ? PTR_BITS : WIN_BITS) + 1;
  localparam int MEM_BITS  = AXES * SAMPLE_BITS;
  localparam int RQ_BITS   = WIN_BITS + DIV_BITS;

  function automatic logic [WIN_BITS-1:0] clamp_window(input logic [WIN_BITS-1:0] v);
    logic [WIN_BITS-1:0] r;
    if (v == '0) begin
      r = WIN_BITS'(1);
    end else if (int'(v) > WINDOW_MAX) begin
      r = WIN_BITS'(WINDOW_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [RQ_BITS-1:0] div_step(input logic [RQ_BITS-1:0] rq,
                                                  input logic [WIN_BITS-1:0] d);
    logic [WIN_BITS:0]   r2;
    logic                ge;
    logic [WIN_BITS-1:0] rem;
    r2  = {rq[RQ_BITS-1:DIV_BITS], rq[DIV_BITS-1]};
    ge  = (r2 >= {1'b0, d});
    rem = ge ? WIN_BITS'(r2 - {1'b0, d}) : r2[WIN_BITS-1:0];
    return {rem, rq[DIV_BITS-2:0], ge};
  endfunction

  gpua_state_t state, state_next;

  logic [WIN_BITS-1:0]     wl;
  logic [WIN_BITS-1:0]     seen;
  logic [PTR_BITS-1:0]     wp;
  logic signed [SUM_BITS-1:0] sum [AXES];
  logic [DIV_CNT_BITS-1:0] step;
  logic [1:0]              axis;
  logic                    warm;
  logic                    out_valid;

  logic [MEM_BITS-1:0]     mem [WINDOW_MAX];
  logic [MEM_BITS-1:0]     rd;
  logic signed [SAMPLE_BITS-1:0] s [AXES];
  logic signed [GRAV_BITS-1:0]   g [AXES];
  logic [RQ_BITS-1:0]      rq;
  logic                    neg;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [DOT_BITS-1:0]  acc;

  logic [CALC_BITS-1:0]    wp_ext;
  logic [CALC_BITS-1:0]    wl_ext;
  logic [PTR_BITS-1:0]     old_addr;
  logic                    full;
  logic [WIN_BITS-1:0]     seen_next;
  logic                    warm_now;
  logic                    accept;
  logic                    load_out;
  logic signed [SUM_BITS-1:0]  div_sum;
  logic [SUM_BITS-1:0]     div_mag;
  logic [RQ_BITS-1:0]      rq_next;
  logic [DIV_BITS-1:0]     quot;
  logic signed [USER_BITS-1:0] u [AXES];
  logic signed [SAMPLE_BITS-1:0] old_s [AXES];

  assign wp_ext   = CALC_BITS'(wp);
  assign wl_ext   = CALC_BITS'(wl);
  assign old_addr = (wp_ext >= wl_ext) ? PTR_BITS'(wp_ext - wl_ext)
                                       : PTR_BITS'(wp_ext + CALC_BITS'(WINDOW_MAX) - wl_ext);
  assign full      = (seen >= wl);
  assign seen_next = full ? seen : seen + WIN_BITS'(1);
  assign warm_now  = (seen_next >= wl);

  assign div_sum = sum[axis];
  assign div_mag = div_sum[SUM_BITS-1] ? SUM_BITS'(-div_sum) : SUM_BITS'(div_sum);
  assign rq_next = div_step(div_step(rq, wl), wl);
  assign quot    = rq_next[DIV_BITS-1:0];

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      u[k]     = {s[k][SAMPLE_BITS-1], s[k]} - {g[k][GRAV_BITS-1], g[k]};
      old_s[k] = rd[(AXES-1-k)*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample.valid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = warm_now ? ST_DIV : ST_MUL;
      end
      ST_DIV: begin
        if (axis == 2'(AXES - 1) && step == DIV_CNT_BITS'(DIV_STEPS)) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (step == DIV_CNT_BITS'(MUL_LAST)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || result.ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    sample.ready = 1'b0;
    load_out     = 1'b0;
    case (state)
      ST_IDLE: begin
        sample.ready = 1'b1;
      end
      ST_DONE: begin
        load_out = !out_valid || result.ready;
      end
      default: begin
        sample.ready = 1'b0;
        load_out     = 1'b0;
      end
    endcase
  end

  assign accept       = sample.valid && sample.ready;
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wl        <= clamp_window(WIN_BITS'(WIN_RESET));
      seen      <= '0;
      wp        <= '0;
      step      <= '0;
      axis      <= '0;
      warm      <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < AXES; k++) sum[k] <= '0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (result.valid && result.ready) out_valid <= 1'b0;
      case (state)
        ST_UPDATE: begin
          for (int k = 0; k < AXES; k++) begin
            sum[k] <= sum[k] - (full ? SUM_BITS'(old_s[k]) : SUM_BITS'(0)) + SUM_BITS'(s[k]);
          end
          wp   <= (wp == PTR_BITS'(WINDOW_MAX - 1)) ? '0 : wp + PTR_BITS'(1);
          seen <= seen_next;
          warm <= warm_now;
          step <= '0;
          axis <= '0;
        end
        ST_DIV: begin
          if (step == DIV_CNT_BITS'(DIV_STEPS)) begin
            step <= '0;
            axis <= axis + 2'd1;
          end else begin
            step <= step + DIV_CNT_BITS'(1);
          end
        end
        ST_MUL: begin
          step <= step + DIV_CNT_BITS'(1);
        end
        default: begin
          step <= step;
        end
      endcase
      if (cfg_wr_en) begin
        wl   <= clamp_window(cfg_wr_data);
        seen <= '0;
        for (int k = 0; k < AXES; k++) sum[k] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s[0] <= sample.accel_x;
      s[1] <= sample.accel_y;
      s[2] <= sample.accel_z;
    end
    case (state)
      ST_READ: begin
        rd <= mem[old_addr];
      end
      ST_UPDATE: begin
        mem[wp] <= {s[0], s[1], s[2]};
        for (int k = 0; k < AXES; k++) g[k] <= '0;
      end
      ST_DIV: begin
        if (step == '0) begin
          rq  <= {WIN_BITS'(0), DIV_BITS'(div_mag)};
          neg <= div_sum[SUM_BITS-1];
        end else begin
          rq <= rq_next;
          if (step == DIV_CNT_BITS'(DIV_STEPS)) begin
            g[axis] <= neg ? GRAV_BITS'(-quot) : GRAV_BITS'(quot);
          end
        end
      end
      ST_MUL: begin
        if (step < DIV_CNT_BITS'(MUL_LAST)) prod <= u[step[1:0]] * g[step[1:0]];
        if (step == '0) begin
          acc <= '0;
        end else begin
          acc <= acc + DOT_BITS'(prod);
        end
      end
      default: begin
        rd <= rd;
      end
    endcase
    if (load_out) begin
      result.gravity_x   <= g[0];
      result.gravity_y   <= g[1];
      result.gravity_z   <= g[2];
      result.user_x      <= u[0];
      result.user_y      <= u[1];
      result.user_z      <= u[2];
      result.dot_product <= acc;
      result.warmed_up   <= warm;
    end
  end

  a_seen_in_window: assert property (@(posedge clk) disable iff (rst) seen <= wl)
    else $error("fill count beyond window");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (seen == '0 && sum[0] == '0 && sum[1] == '0 && sum[2] == '0))
    else $error("window write did not clear state");

  a_warmup_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.warmed_up) |->
      (result.gravity_x == '0 && result.gravity_y == '0 && result.gravity_z == '0 &&
       result.dot_product == '0))
    else $error("nonzero gravity during warm-up");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !sample.ready)
    else $error("second sample taken while busy");

endmodule

FILE: dv/tb_gravity_projected_user_accel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gravity_projected_user_accel_unit
// Self-checking bench for the moving-average gravity removal unit. Sample
// words are queued by a sequencing block and fed by a clocked driver; each
// accepted word runs through a local gravity projector whose result is queued
// and compared field by field against the result channel. The run walks
// through several window settings, extremes included, with random gaps on
// both channels, two long result hold-offs and a drain between phases.
// ----------------------------------------------------------------------------
module tb_gravity_projected_user_accel_unit;
  import gpua_pkg::*;

  localparam int WIN_MAX       = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_WORDS   = 193;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] z;
  } accel_word_t;

  typedef struct {
    logic signed [GRAV_BITS-1:0] grav_x;
    logic signed [GRAV_BITS-1:0] grav_y;
    logic signed [GRAV_BITS-1:0] grav_z;
    logic signed [USER_BITS-1:0] user_x;
    logic signed [USER_BITS-1:0] user_y;
    logic signed [USER_BITS-1:0] user_z;
    logic signed [DOT_BITS-1:0]  dot;
    logic                        warm;
  } motion_word_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_wr_en;
  logic [WIN_BITS-1:0] cfg_wr_data;

  gpua_in_if  accel_ch ();
  gpua_out_if motion_ch ();

  gravity_projected_user_accel_unit #(
    .WINDOW_MAX (WIN_MAX)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .sample      (accel_ch),
    .result      (motion_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  accel_word_t  accel_pending[$];
  motion_word_t motion_expected[$];
  accel_word_t  cur_word;

  // projector state
  longint hist_x[WIN_MAX];
  longint hist_y[WIN_MAX];
  longint hist_z[WIN_MAX];
  longint acc_x, acc_y, acc_z;
  int     ring_ptr;
  int     fill_cnt;
  int     win_len;

  int     err_cnt;
  bit     src_idle_en;
  bit     snk_idle_en;
  int     hold_reqs;
  int     hold_seen;
  int     src_wait;
  bit     src_wait_any;
  int     snk_stall;
  int     snk_hold;
  int     quiet_cycles;

  function automatic int clamp_window(logic [WIN_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > WIN_MAX) return WIN_MAX;
    return int'(v);
  endfunction

  function automatic motion_word_t project_gravity(accel_word_t s);
    motion_word_t r;
    longint sx, sy, sz, gx, gy, gz, ux, uy, uz, dp;
    int     old;
    bit     warm;
    sx = s.x;
    sy = s.y;
    sz = s.z;
    gx = 0;
    gy = 0;
    gz = 0;
    if (fill_cnt >= win_len) begin
      old = (ring_ptr + WIN_MAX - win_len) % WIN_MAX;
      acc_x -= hist_x[old];
      acc_y -= hist_y[old];
      acc_z -= hist_z[old];
    end
    acc_x += sx;
    acc_y += sy;
    acc_z += sz;
    hist_x[ring_ptr] = sx;
    hist_y[ring_ptr] = sy;
    hist_z[ring_ptr] = sz;
    ring_ptr = (ring_ptr + 1) % WIN_MAX;
    if (fill_cnt < win_len) fill_cnt++;
    warm = (fill_cnt >= win_len);
    if (warm) begin
      gx = acc_x / win_len;
      gy = acc_y / win_len;
      gz = acc_z / win_len;
    end
    ux = sx - gx;
    uy = sy - gy;
    uz = sz - gz;
    dp = ux * gx + uy * gy + uz * gz;
    r.grav_x = gx[GRAV_BITS-1:0];
    r.grav_y = gy[GRAV_BITS-1:0];
    r.grav_z = gz[GRAV_BITS-1:0];
    r.user_x = ux[USER_BITS-1:0];
    r.user_y = uy[USER_BITS-1:0];
    r.user_z = uz[USER_BITS-1:0];
    r.dot    = dp[DOT_BITS-1:0];
    r.warm   = warm;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      accel_ch.valid   <= 1'b0;
      accel_ch.accel_x <= '0;
      accel_ch.accel_y <= '0;
      accel_ch.accel_z <= '0;
      src_wait = 0;
    end else begin
      if (accel_ch.valid && accel_ch.ready) begin
        motion_expected.push_back(project_gravity(cur_word));
      end
      if (!(accel_ch.valid && !accel_ch.ready)) begin
        if (src_wait != 0) begin
          if (accel_ch.ready || src_wait_any) src_wait--;
          accel_ch.valid <= 1'b0;
        end else if (accel_pending.size() != 0) begin
          cur_word = accel_pending.pop_front();
          accel_ch.accel_x <= cur_word.x;
          accel_ch.accel_y <= cur_word.y;
          accel_ch.accel_z <= cur_word.z;
          accel_ch.valid   <= 1'b1;
          src_wait     = src_idle_en ? $urandom_range(0, 15) : 0;
          src_wait_any = $urandom_range(0, 1);
        end else begin
          accel_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    motion_word_t e;
    bit           took;
    if (rst) begin
      motion_ch.ready <= 1'b0;
      snk_stall = 0;
      snk_hold  = 0;
    end else begin
      took = motion_ch.valid && motion_ch.ready;
      if (took) begin
        if (motion_expected.size() == 0) begin
          $error("result word with no expectation pending");
          err_cnt++;
        end else begin
          e = motion_expected.pop_front();
          check_field("gravity_x",   e.grav_x, motion_ch.gravity_x);
          check_field("gravity_y",   e.grav_y, motion_ch.gravity_y);
          check_field("gravity_z",   e.grav_z, motion_ch.gravity_z);
          check_field("user_x",      e.user_x, motion_ch.user_x);
          check_field("user_y",      e.user_y, motion_ch.user_y);
          check_field("user_z",      e.user_z, motion_ch.user_z);
          check_field("dot_product", e.dot,    motion_ch.dot_product);
          check_field("warmed_up",   e.warm,   motion_ch.warmed_up);
        end
        snk_stall = snk_idle_en ? $urandom_range(0, 15) : 0;
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        snk_hold  = HOLD_CYCLES;
      end
      if (snk_hold != 0) begin
        snk_hold--;
        motion_ch.ready <= 1'b0;
      end else if (snk_stall != 0) begin
        if (motion_ch.valid && !took) snk_stall--;
        motion_ch.ready <= 1'b0;
      end else begin
        motion_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((accel_ch.valid && accel_ch.ready) || (motion_ch.valid && motion_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic queue_word(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
    accel_word_t w;
    w.x = x;
    w.y = y;
    w.z = z;
    accel_pending.push_back(w);
  endtask

  task automatic write_window(input logic [WIN_BITS-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    win_len  = clamp_window(v);
    fill_cnt = 0;
    acc_x    = 0;
    acc_y    = 0;
    acc_z    = 0;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (accel_pending.size() != 0 || accel_ch.valid || motion_expected.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] near_level(input longint base, input int amp);
    longint v;
    v = base + longint'($urandom_range(0, 2 * amp)) - amp;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic queue_random(input int n, input bit steady);
    longint bx, by, bz;
    int     amp;
    bx  = $signed(16'($urandom));
    by  = $signed(16'($urandom));
    bz  = $signed(16'($urandom));
    amp = 1 << $urandom_range(0, 14);
    for (int i = 0; i < n; i++) begin
      if (steady && $urandom_range(0, 15) != 0)
        queue_word(near_level(bx, amp), near_level(by, amp), near_level(bz, amp));
      else
        queue_word(pick_field(), pick_field(), pick_field());
    end
  endtask

  initial begin
    logic [WIN_BITS-1:0] win_plan[10];
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    accel_ch.valid   = 1'b0;
    accel_ch.accel_x = '0;
    accel_ch.accel_y = '0;
    accel_ch.accel_z = '0;
    motion_ch.ready  = 1'b0;
    err_cnt     = 0;
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    hold_reqs   = 0;
    hold_seen   = 0;
    acc_x       = 0;
    acc_y       = 0;
    acc_z       = 0;
    ring_ptr    = 0;
    fill_cnt    = 0;
    win_len     = clamp_window(WIN_BITS'(WIN_RESET));
    for (int i = 0; i < WIN_MAX; i++) begin
      hist_x[i] = 0;
      hist_y[i] = 0;
      hist_z[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset window: warm-up, then full window with the oldest word dropped
    repeat (8) queue_word(16'h7FFF, 16'h7FFF, 16'h7FFF);
    repeat (8) queue_word(16'h8000, 16'h8000, 16'h8000);
    queue_word(16'h7FFF, 16'h8000, 16'h0000);
    queue_word(16'hFFFF, 16'h0001, 16'h7FFF);
    drain();

    // zero acts as a window of one
    write_window(7'd0);
    queue_word(16'h7FFF, 16'h8000, 16'hFFFF);
    queue_word(16'h8000, 16'h7FFF, 16'h0001);
    queue_word(16'h0000, 16'h0000, 16'h0000);
    drain();

    // deep negative gravity, then a full-scale positive step
    write_window(7'd3);
    repeat (3) queue_word(16'h8000, 16'h8000, 16'h8000);
    queue_word(16'h7FFF, 16'h7FFF, 16'h7FFF);
    drain();

    win_plan = '{7'd1, 7'd64, 7'd127, 7'd2, 7'd0, 7'd65, 7'd3, 7'd16,
                 WIN_BITS'($urandom_range(1, 64)), WIN_BITS'($urandom_range(0, 127))};
    for (int p = 0; p < 10; p++) begin
      write_window(win_plan[p]);
      src_idle_en = (p == 0) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
      snk_idle_en = (p == 0) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
      if (p == 3 || p == 7) hold_reqs++;
      queue_random(PHASE_WORDS, p % 2 == 1 || $urandom_range(0, 1) == 1);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0 && motion_expected.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/gpua_pkg.sv
rtl/gpua_in_if.sv
rtl/gpua_out_if.sv
rtl/gravity_projected_user_accel_unit.sv
dv/tb_gravity_projected_user_accel_unit.sv
